/* rtl/core/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, quiet during reset
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/ccx_pkg.sv */
// ----------------------------------------------------------------------------
// ccx_pkg
// shared types, constants and round helpers for the chacha20 keystream xor
// ----------------------------------------------------------------------------
package ccx_pkg;

  localparam int DoubleRoundsDefault = 10;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY0    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NONCE_L = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_NONCE_H = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_START   = 3'd6;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // load state from registers
    logic qr;        // run one quarter round
    logic fin;       // add input words
  } cmd_t;

  // quarter round index sets, step 0..7 within a double round
  function automatic logic [15:0] qr_sel(input logic [2:0] step);
    logic [15:0] r;
    case (step)
      3'd0: r = {4'd12, 4'd8,  4'd4, 4'd0};
      3'd1: r = {4'd13, 4'd9,  4'd5, 4'd1};
      3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
      3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
      3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
      3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
      3'd6: r = {4'd13, 4'd8,  4'd7, 4'd2};
      default: r = {4'd14, 4'd9, 4'd4, 4'd3};
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ccx_datapath.sv */
// ----------------------------------------------------------------------------
// ccx_datapath
// working words, one quarter round per cycle, keystream block store
// ----------------------------------------------------------------------------
module ccx_datapath (
  input  logic                clk,
  input  ccx_pkg::cmd_t       cmd,
  input  logic [2:0]          step,
  input  logic [255:0]        key,
  input  logic [31:0]         counter,
  input  logic [95:0]         nonce,
  input  logic [5:0]          pos,
  output logic [7:0]          ks_byte
);

  ccx_pkg::word_t init [16];
  ccx_pkg::word_t w [16];
  ccx_pkg::word_t ks [16];
  logic [15:0] sel;
  logic [3:0] ia, ib, ic, id;
  ccx_pkg::word_t a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2, a3, b3, c3, d3;
  ccx_pkg::word_t t;
  ccx_pkg::word_t ks_word;

  // input words
  always_comb begin
    init[0] = ccx_pkg::SIGMA0;
    init[1] = ccx_pkg::SIGMA1;
    init[2] = ccx_pkg::SIGMA2;
    init[3] = ccx_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) init[4+i] = key[32*i +: 32];
    init[12] = counter;
    init[13] = nonce[31:0];
    init[14] = nonce[63:32];
    init[15] = nonce[95:64];
  end

  // quarter round on the selected four words
  always_comb begin
    sel = ccx_pkg::qr_sel(step);
    ia = sel[3:0];
    ib = sel[7:4];
    ic = sel[11:8];
    id = sel[15:12];
    a0 = w[ia]; b0 = w[ib]; c0 = w[ic]; d0 = w[id];
    a1 = a0 + b0; t = d0 ^ a1; d1 = {t[15:0], t[31:16]};
    c1 = c0 + d1; t = b0 ^ c1; b1 = {t[19:0], t[31:20]};
    a2 = a1 + b1; t = d1 ^ a2; d2 = {t[23:0], t[31:24]};
    c2 = c1 + d2; t = b1 ^ c2; b2 = {t[24:0], t[31:25]};
    a3 = a2; b3 = b2; c3 = c2; d3 = d2;
  end

  // working word and keystream registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) w[i] <= init[i];
    end else if (cmd.qr) begin
      w[ia] <= a3;
      w[ib] <= b3;
      w[ic] <= c3;
      w[id] <= d3;
    end
    if (cmd.fin) begin
      for (int i = 0; i < 16; i++) ks[i] <= w[i] + init[i];
    end
  end

  // byte select
  always_comb begin
    ks_word = ks[pos[5:2]];
    ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];
  end

endmodule

/* rtl/core/ccx_ctrl.sv */
// ----------------------------------------------------------------------------
// ccx_ctrl
// message and block sequencing, handshakes and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ccx_ctrl #(
  parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_ovf,
  input  logic [31:0]   start_counter,
  output ccx_pkg::cmd_t cmd,
  output logic [2:0]    step,
  output logic [31:0]   counter,
  output logic [5:0]    pos,
  input  logic [7:0]    ks_byte
);

  localparam int RndW = $clog2(DOUBLE_ROUNDS + 1);

  ccx_pkg::state_t state, state_next;
  logic [RndW-1:0] rnd;
  logic started, ovf;
  logic [7:0] hold_byte;
  logic hold_last;
  logic in_fire, out_free, need_block, first;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign first    = !started;
  assign need_block = first || (!ovf && pos == 6'd0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ccx_pkg::ST_IDLE: begin
        if (in_fire) state_next = ccx_pkg::ST_LOAD;
      end
      ccx_pkg::ST_LOAD: begin
        state_next = need_block ? ccx_pkg::ST_ROUND : ccx_pkg::ST_OUT;
      end
      ccx_pkg::ST_ROUND: begin
        if (step == 3'd7 && rnd == RndW'(DOUBLE_ROUNDS - 1)) state_next = ccx_pkg::ST_FINAL;
      end
      ccx_pkg::ST_FINAL: state_next = ccx_pkg::ST_OUT;
      ccx_pkg::ST_OUT: begin
        if (out_free) state_next = ccx_pkg::ST_IDLE;
      end
      default: state_next = ccx_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ccx_pkg::ST_IDLE:  in_ready = 1'b1;
      ccx_pkg::ST_LOAD:  cmd.load = 1'b1;
      ccx_pkg::ST_ROUND: cmd.qr = 1'b1;
      ccx_pkg::ST_FINAL: cmd.fin = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccx_pkg::ST_IDLE;
      started <= 1'b0;
      ovf <= 1'b0;
      pos <= '0;
      counter <= '0;
      step <= '0;
      rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ccx_pkg::ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      // message start reloads counter before the block is built
      if (state == ccx_pkg::ST_IDLE && in_fire && first) begin
        counter <= start_counter;
        pos <= '0;
        ovf <= 1'b0;
        started <= 1'b1;
      end
      if (state == ccx_pkg::ST_LOAD) begin
        step <= '0;
        rnd <= '0;
      end
      if (state == ccx_pkg::ST_ROUND) begin
        step <= step + 3'd1;
        if (step == 3'd7) rnd <= rnd + RndW'(1);
      end
      if (state == ccx_pkg::ST_OUT && out_free) begin
        out_ovf <= ovf;
        out_byte <= ovf ? 8'd0 : (hold_byte ^ ks_byte);
        out_last <= hold_last;
        if (!ovf && pos == 6'd63) begin
          if (counter == 32'hFFFFFFFF) ovf <= 1'b1;
          else counter <= counter + 32'd1;
        end
        pos <= hold_last ? 6'd0 : pos + 6'd1;
        if (hold_last) started <= 1'b0;
      end
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == ccx_pkg::ST_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_fire_load, clk, rst, in_fire, state == ccx_pkg::ST_LOAD, "accept not followed by load")
  `ASSERT_IMPL(a_ovf_zero, clk, rst, out_valid && out_ovf, out_byte == 8'd0, "overflow byte nonzero")
  `ASSERT_IMPL(a_round_step, clk, rst, state == ccx_pkg::ST_ROUND, rnd < RndW'(DOUBLE_ROUNDS), "round count past end")

endmodule

/* rtl/core/chacha20_keystream_xor.sv */
// a byte that opens a keystream block passes load, the round steps, the final add and
// the output register, one quarter round per cycle in the round unit; every other byte
// passes load and the output register only; a new byte is accepted only back in idle,
// once the last one is registered at the output, so output back-pressure holds off input
// reset: synchronous active-high rst clears control state and all config registers
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// rfc 8439 chacha20 stream xor with config registers, one byte per item
// ----------------------------------------------------------------------------
module chacha20_keystream_xor #(
  parameter int DOUBLE_ROUNDS = ccx_pkg::DoubleRoundsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,   // out_last
  output logic        m_tuser,   // counter_overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ccx_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  logic [255:0] key;
  logic [95:0]  nonce;
  logic [31:0]  start_counter;
  ccx_pkg::cmd_t cmd;
  logic [2:0] step;
  logic [31:0] counter;
  logic [5:0] pos;
  logic [7:0] ks_byte;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      nonce <= '0;
      start_counter <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccx_pkg::REG_KEY0:    key[63:0]    <= cfg_data;
        ccx_pkg::REG_KEY1:    key[127:64]  <= cfg_data;
        ccx_pkg::REG_KEY2:    key[191:128] <= cfg_data;
        ccx_pkg::REG_KEY3:    key[255:192] <= cfg_data;
        ccx_pkg::REG_NONCE_L: nonce[63:0]  <= cfg_data;
        ccx_pkg::REG_NONCE_H: nonce[95:64] <= cfg_data[31:0];
        ccx_pkg::REG_START:   start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  ccx_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata), .in_last(s_tlast),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_byte(m_tdata),
    .out_last(m_tlast), .out_ovf(m_tuser),
    .start_counter, .cmd, .step, .counter, .pos, .ks_byte
  );

  ccx_datapath u_dp (
    .clk, .cmd, .step, .key, .counter, .nonce, .pos, .ks_byte
  );

endmodule
